/* sv/ipip_pkg.sv */
// ----------------------------------------------------------------------------
// ipip_pkg
// Shared types, constants and helpers for the ipip tunnel encap/decap core.
// ----------------------------------------------------------------------------
package ipip_pkg;

   localparam int IPIP_HDR_BYTES   = 34;
   localparam int IPIP_ETH_BYTES   = 14;
   localparam int IPIP_OUTER_BYTES = 20;
   localparam int IPIP_QUEUE_DEPTH = 16;

   localparam logic [5:0]  HDR_LAST_IDX   = 6'(IPIP_HDR_BYTES - 1);
   localparam logic [5:0]  ETH_LAST_IDX   = 6'(IPIP_ETH_BYTES - 1);
   localparam logic [5:0]  ENCAP_LAST_IDX = 6'(IPIP_HDR_BYTES + IPIP_OUTER_BYTES - 1);
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_IPIP     = 8'd4;
   localparam logic [7:0]  OUTER_VER_IHL  = 8'h45;

   localparam logic [31:0] RST_SUBNET_ADDRESS = 32'hc0a80100;
   localparam logic [31:0] RST_SUBNET_MASK    = 32'hffffff00;
   localparam logic [31:0] RST_LOCAL_ADDRESS  = 32'h0a000002;
   localparam logic [31:0] RST_REMOTE_ADDRESS = 32'h0a000001;
   localparam logic [7:0]  RST_REDIRECT_PORT  = 8'd5;
   localparam logic [7:0]  RST_OUTER_TTL      = 8'd64;

   typedef enum logic [2:0] {
      CSR_DECAP_MODE     = 3'd0,
      CSR_SUBNET_ADDRESS = 3'd1,
      CSR_SUBNET_MASK    = 3'd2,
      CSR_LOCAL_ADDRESS  = 3'd3,
      CSR_REMOTE_ADDRESS = 3'd4,
      CSR_REDIRECT_PORT  = 3'd5,
      CSR_OUTER_TTL      = 3'd6
   } csr_index_type;

   typedef enum logic {
      PH_COLLECT = 1'b0,
      PH_STREAM  = 1'b1
   } phase_type;

   typedef enum logic {
      JOB_BYTE = 1'b0,
      JOB_HDR  = 1'b1
   } job_kind_type;

   typedef enum logic [1:0] {
      HDR_SHORT = 2'd0,
      HDR_PASS  = 2'd1,
      HDR_ENCAP = 2'd2,
      HDR_DECAP = 2'd3
   } hdr_mode_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_end;
      logic       out_redirect;
      logic [7:0] out_port;
   } rsp_type;

   typedef struct packed {
      logic        decap_mode;
      logic [31:0] subnet_address;
      logic [31:0] subnet_mask;
      logic [31:0] local_address;
      logic [31:0] remote_address;
      logic [7:0]  redirect_port;
      logic [7:0]  outer_ttl;
   } cfg_type;

   typedef struct packed {
      job_kind_type kind;
      hdr_mode_type hmode;
      logic         bank;
      logic [5:0]   len;
      logic [7:0]   data;
      logic         last;
      logic         redirect;
      logic [15:0]  total;
      logic [15:0]  cksum;
   } job_type;

   typedef struct packed {
      logic       en;
      logic       bank;
      logic [5:0] idx;
      logic [7:0] data;
   } wr_port_type;

   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

   function automatic logic [7:0] outer_byte(input logic [4:0] j, input logic [15:0] total,
                                             input logic [15:0] cksum, input cfg_type cfg);
      logic [7:0] v;
      v = 8'h00;
      unique case (j)
         5'd0:  v = OUTER_VER_IHL;
         5'd2:  v = total[15:8];
         5'd3:  v = total[7:0];
         5'd8:  v = cfg.outer_ttl;
         5'd9:  v = PROTO_IPIP;
         5'd10: v = cksum[15:8];
         5'd11: v = cksum[7:0];
         5'd12: v = cfg.local_address[31:24];
         5'd13: v = cfg.local_address[23:16];
         5'd14: v = cfg.local_address[15:8];
         5'd15: v = cfg.local_address[7:0];
         5'd16: v = cfg.remote_address[31:24];
         5'd17: v = cfg.remote_address[23:16];
         5'd18: v = cfg.remote_address[15:8];
         5'd19: v = cfg.remote_address[7:0];
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

/* sv/ipip_front.sv */
// ----------------------------------------------------------------------------
// ipip_front
// Collects the frame header into a bank of the header store, classifies the
// frame and queues header and streaming jobs for the back end.
// ----------------------------------------------------------------------------
module ipip_front (
   input  logic                 clock,
   input  logic                 reset,
   input  ipip_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipip_pkg::req_type    req_payload,
   output logic                 push,
   output ipip_pkg::job_type    push_job,
   input  logic                 fifo_full,
   output ipip_pkg::wr_port_type wr,
   input  ipip_pkg::release_type rel
);
   import ipip_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  count_ff, count_in;
   logic        bank_ff, bank_in;
   logic [1:0]  busy_ff, busy_in;
   logic        push_job_redir_ff, push_job_redir_in;
   logic [15:0] etype_ff;
   logic [13:0] frag_ff;
   logic [15:0] tlen_ff;
   logic [7:0]  proto_ff;
   logic [23:0] dest_ff;
   logic [18:0] cfg_sum_ff;

   logic        accept;
   logic        hdr_done;
   logic [31:0] dest;
   logic        ok;
   logic        do_encap;
   logic        do_decap;
   logic [15:0] total;
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   assign accept   = req_valid && req_ready;
   assign hdr_done = count_ff == HDR_LAST_IDX;

   always_comb begin
      dest     = {dest_ff, req_payload.frame_byte};
      ok       = (etype_ff == ETHERTYPE_IPV4) && (frag_ff == 14'd0);
      do_encap = ok && !cfg.decap_mode && ((dest & cfg.subnet_mask) == cfg.subnet_address);
      do_decap = ok && cfg.decap_mode && (proto_ff == PROTO_IPIP);
      total    = tlen_ff + 16'(IPIP_OUTER_BYTES);
      sum      = {1'b0, cfg_sum_ff} + {4'd0, total};
      fold1    = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
      fold2    = fold1[15:0] + {15'd0, fold1[16]};
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bank_in  = bank_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_COLLECT: begin
               if (req_payload.frame_end) begin
                  count_in = 6'd0;
                  bank_in  = ~bank_ff;
               end else if (hdr_done) begin
                  phase_in = PH_STREAM;
                  count_in = 6'd0;
                  bank_in  = ~bank_ff;
               end else begin
                  count_in = count_ff + 6'd1;
               end
            end
            PH_STREAM: begin
               if (req_payload.frame_end) begin
                  phase_in = PH_COLLECT;
               end
            end
            default: phase_in = PH_COLLECT;
         endcase
      end
   end

   // outputs
   always_comb begin
      req_ready = !fifo_full && !(phase_ff == PH_COLLECT && count_ff == 6'd0 && busy_ff[bank_ff]);
      push      = 1'b0;
      push_job  = '0;
      wr.en     = accept && phase_ff == PH_COLLECT;
      wr.bank   = bank_ff;
      wr.idx    = count_ff;
      wr.data   = req_payload.frame_byte;
      unique case (phase_ff)
         PH_COLLECT: begin
            push           = accept && (req_payload.frame_end || hdr_done);
            push_job.kind  = JOB_HDR;
            push_job.bank  = bank_ff;
            push_job.len   = count_ff;
            push_job.last  = req_payload.frame_end;
            push_job.total = total;
            push_job.cksum = ~fold2;
            if (!hdr_done) begin
               push_job.hmode = HDR_SHORT;
            end else if (do_encap) begin
               push_job.hmode    = HDR_ENCAP;
               push_job.redirect = 1'b1;
            end else if (do_decap) begin
               push_job.hmode = HDR_DECAP;
            end else begin
               push_job.hmode = HDR_PASS;
            end
         end
         PH_STREAM: begin
            push              = accept;
            push_job.kind     = JOB_BYTE;
            push_job.data     = req_payload.frame_byte;
            push_job.last     = req_payload.frame_end;
            push_job.redirect = push_job_redir_ff;
         end
         default: push = 1'b0;
      endcase
   end

   always_comb begin
      push_job_redir_in = push_job_redir_ff;
      if (accept && phase_ff == PH_COLLECT && hdr_done) begin
         push_job_redir_in = do_encap;
      end
      busy_in = busy_ff;
      if (rel.en) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (push && phase_ff == PH_COLLECT) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_COLLECT;
         count_ff          <= 6'd0;
         bank_ff           <= 1'b0;
         busy_ff           <= 2'b00;
         push_job_redir_ff <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         count_ff          <= count_in;
         bank_ff           <= bank_in;
         busy_ff           <= busy_in;
         push_job_redir_ff <= push_job_redir_in;
      end
   end

   // header field capture
   always_ff @(posedge clock) begin
      cfg_sum_ff <= 19'({OUTER_VER_IHL, 8'h00}) + 19'({cfg.outer_ttl, PROTO_IPIP})
                  + 19'(cfg.local_address[31:16]) + 19'(cfg.local_address[15:0])
                  + 19'(cfg.remote_address[31:16]) + 19'(cfg.remote_address[15:0]);
      if (wr.en) begin
         unique case (count_ff)
            6'd12:   etype_ff[15:8] <= req_payload.frame_byte;
            6'd13:   etype_ff[7:0]  <= req_payload.frame_byte;
            6'd16:   tlen_ff[15:8]  <= req_payload.frame_byte;
            6'd17:   tlen_ff[7:0]   <= req_payload.frame_byte;
            6'd20:   frag_ff[13:8]  <= req_payload.frame_byte[5:0];
            6'd21:   frag_ff[7:0]   <= req_payload.frame_byte;
            6'd23:   proto_ff       <= req_payload.frame_byte;
            6'd30:   dest_ff[23:16] <= req_payload.frame_byte;
            6'd31:   dest_ff[15:8]  <= req_payload.frame_byte;
            6'd32:   dest_ff[7:0]   <= req_payload.frame_byte;
            default: ;
         endcase
      end
   end

   a_first_byte_bank_free: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_COLLECT && count_ff == 6'd0 |-> !busy_ff[bank_ff])
      else $error("header bank overwritten while in use");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("job pushed into full queue");
   a_stream_push_is_byte: assert property (@(posedge clock) disable iff (reset)
      push && phase_ff == PH_STREAM |-> push_job.kind == JOB_BYTE)
      else $error("stream request queued as header job");

endmodule

/* sv/ipip_job_fifo.sv */
// ----------------------------------------------------------------------------
// ipip_job_fifo
// Short queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module ipip_job_fifo #(
   parameter int DEPTH = ipip_pkg::IPIP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipip_pkg::job_type push_job,
   input  logic              pop,
   output ipip_pkg::job_type head,
   output logic              full,
   output logic              empty
);
   import ipip_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type         entry_ff [DEPTH];
   logic [AW-1:0]   wp_ff, wp_in;
   logic [AW-1:0]   rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;

   assign full  = cnt_ff == (AW+1)'(DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = entry_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("pop from empty queue");

endmodule

/* sv/ipip_back.sv */
// ----------------------------------------------------------------------------
// ipip_back
// Holds the two-bank header store, plays out queued header jobs unchanged, with
// the outer header inserted or with the outer header dropped, and passes stream bytes.
// ----------------------------------------------------------------------------
module ipip_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ipip_pkg::cfg_type     cfg,
   input  ipip_pkg::wr_port_type wr,
   input  ipip_pkg::job_type     head,
   input  logic                  empty,
   output logic                  pop,
   output ipip_pkg::release_type rel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ipip_pkg::rsp_type     rsp_payload
);
   import ipip_pkg::*;

   logic [7:0] mem [2*IPIP_HDR_BYTES];
   logic [7:0] rd_ff;

   job_type    job_ff, job_in;
   logic       active_ff, active_in;
   logic [5:0] k_ff, k_in;

   logic       b_valid_ff, b_valid_in;
   logic       b_mem_ff, b_mem_in;
   logic [7:0] b_byte_ff, b_byte_in;
   logic       b_last_ff, b_last_in;
   logic       b_redir_ff, b_redir_in;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic       out_take;
   logic       adv;
   logic       issue;
   logic       is_encap;
   logic       in_outer;
   logic [5:0] src_idx;
   logic [6:0] raddr;
   logic [6:0] waddr;
   logic [5:0] lastk;
   logic       at_last;

   assign out_take = !rsp_valid_ff || rsp_ready;
   assign adv      = !b_valid_ff || out_take;
   assign issue    = adv && active_ff;
   assign pop      = adv && !active_ff && !empty;
   assign is_encap = job_ff.hmode == HDR_ENCAP;
   assign in_outer = is_encap && k_ff >= 6'(IPIP_ETH_BYTES) && k_ff < 6'(IPIP_HDR_BYTES);
   assign src_idx  = (is_encap && k_ff >= 6'(IPIP_HDR_BYTES)) ? k_ff - 6'(IPIP_OUTER_BYTES) : k_ff;
   assign raddr    = job_ff.bank ? {1'b0, src_idx} + 7'(IPIP_HDR_BYTES) : {1'b0, src_idx};
   assign waddr    = wr.bank ? {1'b0, wr.idx} + 7'(IPIP_HDR_BYTES) : {1'b0, wr.idx};
   assign at_last  = k_ff == lastk;
   assign rel.en   = issue && at_last;
   assign rel.bank = job_ff.bank;

   always_comb begin
      unique case (job_ff.hmode)
         HDR_SHORT: lastk = job_ff.len;
         HDR_PASS:  lastk = HDR_LAST_IDX;
         HDR_ENCAP: lastk = ENCAP_LAST_IDX;
         HDR_DECAP: lastk = ETH_LAST_IDX;
         default:   lastk = HDR_LAST_IDX;
      endcase
   end

   always_comb begin
      job_in     = job_ff;
      active_in  = active_ff;
      k_in       = k_ff;
      b_valid_in = b_valid_ff;
      b_mem_in   = b_mem_ff;
      b_byte_in  = b_byte_ff;
      b_last_in  = b_last_ff;
      b_redir_in = b_redir_ff;
      if (adv) begin
         b_valid_in = issue || (pop && head.kind == JOB_BYTE);
         if (active_ff) begin
            b_mem_in   = !in_outer;
            b_byte_in  = outer_byte(5'(k_ff - 6'(IPIP_ETH_BYTES)), job_ff.total,
                                    job_ff.cksum, cfg);
            b_last_in  = at_last && job_ff.last;
            b_redir_in = is_encap;
            k_in       = k_ff + 6'd1;
            if (at_last) begin
               active_in = 1'b0;
            end
         end else begin
            b_mem_in   = 1'b0;
            b_byte_in  = head.data;
            b_last_in  = head.last;
            b_redir_in = head.redirect;
            if (pop && head.kind == JOB_HDR) begin
               active_in = 1'b1;
               job_in    = head;
               k_in      = 6'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         b_valid_ff <= b_valid_in;
         if (out_take) begin
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      k_ff       <= k_in;
      b_mem_ff   <= b_mem_in;
      b_byte_ff  <= b_byte_in;
      b_last_ff  <= b_last_in;
      b_redir_ff <= b_redir_in;
      if (out_take && b_valid_ff) begin
         rsp_ff.out_byte     <= b_mem_ff ? rd_ff : b_byte_ff;
         rsp_ff.out_end      <= b_last_ff;
         rsp_ff.out_redirect <= b_redir_ff;
         rsp_ff.out_port     <= b_redir_ff ? cfg.redirect_port : 8'd0;
      end
   end

   // header store
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[waddr] <= wr.data;
      end
      if (adv) begin
         rd_ff <= mem[raddr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_active_is_hdr: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> job_ff.kind == JOB_HDR)
      else $error("sequencer running a non-header job");
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> k_ff <= lastk)
      else $error("header index past its end");
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_take |=> b_valid_ff && $stable(b_byte_ff) && $stable(b_last_ff))
      else $error("stalled stage lost its request");
   a_no_pop_while_active: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !pop)
      else $error("queue popped during header playout");

endmodule

/* sv/ipip_tunnel_encap_decap_core.sv */
// ----------------------------------------------------------------------------
// ipip_tunnel_encap_decap_core
// IPv4-in-IPv4 tunnel encapsulation and decapsulation on a byte stream.
//
//   channel  | ports             | direction | content
//   ---------+-------------------+-----------+-------------------------------
//   request  | req_valid/ready   | in        | frame byte, frame end
//   response | rsp_valid/ready   | out       | byte, end, redirect, port
//   csr      | csr_write_en      | in        | index, 32-bit write data
//
// A request is taken every cycle while the job queue has room; the first
// 33 bytes of a frame only fill the header store, the 34th or an early end
// queues a header job played out at one byte per cycle (1 to 54 bytes).
// Header bytes of a frame wait until its header store bank is released.
// Responses leave from an output register; a stalled rsp_ready holds the
// pipeline and fills the queue. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module ipip_tunnel_encap_decap_core #(
   parameter int QUEUE_DEPTH = ipip_pkg::IPIP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ipip_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipip_pkg::rsp_type rsp_payload,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import ipip_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        push;
   job_type     push_job;
   logic        pop;
   job_type     head;
   logic        full;
   logic        empty;
   wr_port_type wr;
   release_type rel;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DECAP_MODE:     cfg_in.decap_mode     = csr_wdata[0];
            CSR_SUBNET_ADDRESS: cfg_in.subnet_address = csr_wdata;
            CSR_SUBNET_MASK:    cfg_in.subnet_mask    = csr_wdata;
            CSR_LOCAL_ADDRESS:  cfg_in.local_address  = csr_wdata;
            CSR_REMOTE_ADDRESS: cfg_in.remote_address = csr_wdata;
            CSR_REDIRECT_PORT:  cfg_in.redirect_port  = csr_wdata[7:0];
            CSR_OUTER_TTL:      cfg_in.outer_ttl      = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decap_mode     <= 1'b0;
         cfg_ff.subnet_address <= RST_SUBNET_ADDRESS;
         cfg_ff.subnet_mask    <= RST_SUBNET_MASK;
         cfg_ff.local_address  <= RST_LOCAL_ADDRESS;
         cfg_ff.remote_address <= RST_REMOTE_ADDRESS;
         cfg_ff.redirect_port  <= RST_REDIRECT_PORT;
         cfg_ff.outer_ttl      <= RST_OUTER_TTL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipip_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_job    (push_job),
      .fifo_full   (full),
      .wr          (wr),
      .rel         (rel)
   );

   ipip_job_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   ipip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .wr          (wr),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rel         (rel),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the ipip tunnel encap/decap core byte by byte against a predictor
// kept in step with each accepted request. Frames of many shapes are sent in
// bursts under several register settings while the response side stalls.
// ----------------------------------------------------------------------------
module tb;
   import ipip_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   ipip_tunnel_encap_decap_core DUT (.*);

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      stall_hold = 0;
   int      long_hold = 0;
   int      gap_left = 0;
   int      burst_left = 0;
   bit      send_enable = 1'b0;

   // predictor state
   cfg_type    cfg;
   logic [7:0] hdr_store[IPIP_HDR_BYTES];
   int         hdr_count;
   bit         streaming;
   bit         frame_redir;

   function automatic logic [15:0] be16(input int i);
      return {hdr_store[i], hdr_store[i+1]};
   endfunction

   task automatic push_rsp(input logic [7:0] b, input logic e, input logic r);
      rsp_type x;
      x.out_byte = b;
      x.out_end = e;
      x.out_redirect = r;
      x.out_port = r ? cfg.redirect_port : 8'h00;
      expected_rsps.push_back(x);
   endtask

   task automatic predict_frame_byte(input req_type q);
      logic [7:0]  outer[20];
      logic [31:0] sum;
      logic [31:0] dest;
      bit          ok;
      if (streaming) begin
         push_rsp(q.frame_byte, q.frame_end, frame_redir);
         if (q.frame_end) begin
            streaming = 0;
            hdr_count = 0;
            frame_redir = 0;
         end
         return;
      end
      hdr_store[hdr_count] = q.frame_byte;
      hdr_count++;
      if (hdr_count < IPIP_HDR_BYTES) begin
         if (q.frame_end) begin
            for (int i = 0; i < hdr_count; i++)
               push_rsp(hdr_store[i], i + 1 == hdr_count, 1'b0);
            hdr_count = 0;
         end
         return;
      end
      ok = be16(12) == ETHERTYPE_IPV4 && (be16(20) & 16'h3fff) == 0;
      dest = {be16(30), be16(32)};
      if (ok && !cfg.decap_mode && (dest & cfg.subnet_mask) == cfg.subnet_address) begin
         outer = '{default: 8'h00};
         {outer[2], outer[3]} = be16(16) + 16'd20;
         outer[0] = 8'h45;
         outer[8] = cfg.outer_ttl;
         outer[9] = 8'd4;
         for (int i = 0; i < 4; i++) begin
            outer[12+i] = cfg.local_address[31-8*i -: 8];
            outer[16+i] = cfg.remote_address[31-8*i -: 8];
         end
         sum = 0;
         for (int i = 0; i < 20; i += 2)
            sum += {outer[i], outer[i+1]};
         while (sum > 32'hffff)
            sum = (sum & 32'hffff) + (sum >> 16);
         {outer[10], outer[11]} = ~sum[15:0];
         frame_redir = 1;
         for (int i = 0; i < 14; i++) push_rsp(hdr_store[i], 1'b0, 1'b1);
         for (int i = 0; i < 20; i++) push_rsp(outer[i], 1'b0, 1'b1);
         for (int i = 14; i < 34; i++)
            push_rsp(hdr_store[i], q.frame_end && i == 33, 1'b1);
      end else if (ok && cfg.decap_mode && hdr_store[23] == 8'd4) begin
         frame_redir = 0;
         for (int i = 0; i < 14; i++)
            push_rsp(hdr_store[i], q.frame_end && i == 13, 1'b0);
      end else begin
         frame_redir = 0;
         for (int i = 0; i < 34; i++)
            push_rsp(hdr_store[i], q.frame_end && i == 33, 1'b0);
      end
      hdr_count = 0;
      if (q.frame_end) frame_redir = 0;
      else streaming = 1;
   endtask

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_frame_byte(req_payload);
            void'(pending_reqs.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold until accepted
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (send_enable && pending_reqs.size() > 0) begin
            req_payload <= pending_reqs[0];
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(40, 1);
               gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and stall pattern
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected", rsp_payload, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.out_byte !== want.out_byte)
                  report("out_byte", rsp_payload, want);
               if (rsp_payload.out_end !== want.out_end)
                  report("out_end", rsp_payload, want);
               if (rsp_payload.out_redirect !== want.out_redirect)
                  report("out_redirect", rsp_payload, want);
               if (rsp_payload.out_port !== want.out_port)
                  report("out_port", rsp_payload, want);
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (stall_hold > 0) begin
            stall_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ((cycle_count / 500) % 2 == 1 && $urandom_range(7, 0) == 0)
               stall_hold = $urandom_range(5, 1);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] v);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DECAP_MODE:     cfg.decap_mode = v[0];
         CSR_SUBNET_ADDRESS: cfg.subnet_address = v;
         CSR_SUBNET_MASK:    cfg.subnet_mask = v;
         CSR_LOCAL_ADDRESS:  cfg.local_address = v;
         CSR_REMOTE_ADDRESS: cfg.remote_address = v;
         CSR_REDIRECT_PORT:  cfg.redirect_port = v[7:0];
         CSR_OUTER_TTL:      cfg.outer_ttl = v[7:0];
         default: ;
      endcase
   endtask

   // queue one frame of len random bytes; ipv4, frag, proto and dest shape its header fields
   task automatic queue_frame(input int len, input bit ipv4, input bit frag,
                              input logic [7:0] proto, input logic [31:0] dest);
      logic [7:0] f[];
      req_type    q;
      f = new[len];
      foreach (f[i]) f[i] = $urandom;
      if (len > 13 && ipv4) begin f[12] = 8'h08; f[13] = 8'h00; end
      if (len > 21 && !frag) begin f[20] = f[20] & 8'hc0; f[21] = 8'h00; end
      if (len > 23) f[23] = proto;
      if (len > 33) {f[30], f[31], f[32], f[33]} = dest;
      foreach (f[i]) begin
         q.frame_byte = f[i];
         q.frame_end = (i == len - 1);
         pending_reqs.push_back(q);
      end
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(9, 0);
      if (r < 2) return $urandom_range(33, 1);
      if (r < 4) return 34;
      if (r == 9) return $urandom_range(80, 35);
      return $urandom_range(42, 35);
   endfunction

   task automatic random_frames(input int bytes);
      int start;
      logic [31:0] d;
      start = pending_reqs.size();
      while (pending_reqs.size() - start < bytes) begin
         d = ($urandom_range(3, 0) != 0) ? ((cfg.subnet_address & cfg.subnet_mask)
             | ($urandom & ~cfg.subnet_mask)) : $urandom;
         queue_frame(pick_len(), $urandom_range(5, 0) != 0, $urandom_range(5, 0) == 0,
                     ($urandom_range(2, 0) != 0) ? 8'd4 : 8'($urandom), d);
      end
   endtask

   initial begin
      cfg = '{decap_mode: 1'b0, subnet_address: RST_SUBNET_ADDRESS,
              subnet_mask: RST_SUBNET_MASK, local_address: RST_LOCAL_ADDRESS,
              remote_address: RST_REMOTE_ADDRESS, redirect_port: RST_REDIRECT_PORT,
              outer_ttl: RST_OUTER_TTL};
      hdr_count = 0;
      streaming = 0;
      frame_redir = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short, exact 34, encap, fragment, non ipv4
      queue_frame(1, 1, 0, 8'd4, 32'hc0a80101);
      queue_frame(34, 1, 0, 8'd4, 32'hc0a801ff);
      queue_frame(36, 1, 0, 8'd6, 32'hc0a80100);
      queue_frame(35, 1, 1, 8'd4, 32'hc0a80102);
      queue_frame(35, 0, 0, 8'd4, 32'hc0a80103);
      send_enable = 1;
      wait_drained();

      // pressure: hold the response side while requests keep flowing
      send_enable = 0;
      random_frames(80);
      long_hold = 300;
      send_enable = 1;
      wait (long_hold == 0);
      wait_drained();

      csr_write(CSR_DECAP_MODE, 32'h1);
      csr_write(CSR_REDIRECT_PORT, 32'hff);
      queue_frame(34, 1, 0, 8'd4, 32'h0);
      queue_frame(40, 1, 0, 8'd4, 32'hffffffff);
      random_frames(40);
      wait_drained();

      csr_write(CSR_DECAP_MODE, 32'h0);
      csr_write(CSR_SUBNET_ADDRESS, 32'h0);
      csr_write(CSR_SUBNET_MASK, 32'h0);
      csr_write(CSR_LOCAL_ADDRESS, 32'hffffffff);
      csr_write(CSR_REMOTE_ADDRESS, 32'hffffffff);
      csr_write(CSR_OUTER_TTL, 32'hff);
      csr_write(CSR_REDIRECT_PORT, 32'h0);
      random_frames(40);
      wait_drained();

      csr_write(CSR_SUBNET_ADDRESS, 32'hffffffff);
      csr_write(CSR_SUBNET_MASK, 32'hffffffff);
      csr_write(CSR_LOCAL_ADDRESS, 32'h0);
      csr_write(CSR_REMOTE_ADDRESS, 32'h0);
      csr_write(CSR_OUTER_TTL, 32'h0);
      queue_frame(34, 1, 0, 8'h00, 32'hffffffff);
      wait_drained();
      csr_write(CSR_SUBNET_ADDRESS, $urandom & 32'hfff00000);
      csr_write(CSR_SUBNET_MASK, 32'hfff00000);
      csr_write(CSR_LOCAL_ADDRESS, $urandom);
      csr_write(CSR_REMOTE_ADDRESS, $urandom);
      csr_write(CSR_OUTER_TTL, $urandom);
      csr_write(CSR_REDIRECT_PORT, $urandom);
      random_frames(20);
      wait_drained();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
sv/ipip_pkg.sv
sv/ipip_front.sv
sv/ipip_job_fifo.sv
sv/ipip_back.sv
sv/ipip_tunnel_encap_decap_core.sv
test/tb.sv
